### rtl/lprd_pkg.sv
package lprd_pkg;

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic REG_FIRST_SEQUENCE = 1'b0;
  localparam logic REG_FIRST_OFFSET   = 1'b1;

  localparam logic [DATA_W-1:0] FIRST_SEQUENCE_RST = 32'd1;
  localparam logic [DATA_W-1:0] FIRST_OFFSET_RST   = 32'd0;

  localparam logic [1:0]        PREFIX_LAST    = 2'd3;
  localparam logic [1:0]        PREFIX_FIRST   = 2'd0;
  localparam logic [3:0]        ID_FIRST_INDEX = 4'd4;
  localparam logic [3:0]        ID_END_INDEX   = 4'd8;
  localparam logic [DATA_W-1:0] ID_MIN_LENGTH  = 32'd8;

endpackage

### rtl/length_prefixed_record_deframer.sv
// Record deframer: takes one byte per cycle of a stream of records, each a
// 4-byte little-endian payload length followed by that many payload bytes,
// and gives one result per record at its last byte (at the last prefix byte
// for an empty record): start offset, sequence number, payload length and
// the file identifier taken from payload bytes 4..7 (zero and not valid for
// payloads under 8 bytes). Every byte is handled in the cycle it is accepted,
// so it sustains one byte per cycle while not stalled; a result is registered
// and appears in the cycle after its closing byte, then stays in the output
// register until taken. Input stall is raised only while a result is held
// and the output side stalls. Offsets wrap at 2**OFFSET_BITS (the low 32 bits
// are reported), sequence numbers at 2**32. first_sequence (byte address 0)
// and first_offset (byte address 4) reload the running counters when written.
module length_prefixed_record_deframer #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lprd_pkg::ADDR_W-1:0]   paddr,
  input  logic [lprd_pkg::DATA_W-1:0]   pwdata,
  output logic [lprd_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [31:0]                   record_offset_o,
  output logic [31:0]                   record_sequence_o,
  output logic [31:0]                   payload_length_o,
  output logic [31:0]                   file_id_o,
  output logic                          file_id_valid_o
);
  import lprd_pkg::*;

  logic                   cfg_wr;
  logic                   accept;
  logic                   emit_c;
  logic [31:0]            emit_len_c;
  logic [31:0]            ls_base_c;
  logic [31:0]            byte_placed_c;
  logic [31:0]            id_placed_c;
  logic [31:0]            bytes_left_dec_c;

  logic [DATA_W-1:0]      first_seq_q;
  logic [DATA_W-1:0]      first_off_q;
  logic                   in_payload_q, in_payload_d;
  logic [1:0]             prefix_count_q, prefix_count_d;
  logic [31:0]            length_shift_q, length_shift_d;
  logic [31:0]            bytes_left_q, bytes_left_d;
  logic [3:0]             payload_index_q, payload_index_d;
  logic [31:0]            id_capture_q, id_capture_d;
  logic [OFFSET_BITS-1:0] next_offset_q, next_offset_d;
  logic [OFFSET_BITS-1:0] record_start_q, record_start_d;
  logic [31:0]            next_seq_q, next_seq_d;
  logic                   out_valid_q;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign prdata     = (paddr[2] == REG_FIRST_OFFSET) ? first_off_q : first_seq_q;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    case (prefix_count_q)
      2'd0:    byte_placed_c = {24'd0, data_byte_i};
      2'd1:    byte_placed_c = {16'd0, data_byte_i, 8'd0};
      2'd2:    byte_placed_c = {8'd0, data_byte_i, 16'd0};
      default: byte_placed_c = {data_byte_i, 24'd0};
    endcase
  end

  always_comb begin
    case (payload_index_q[1:0])
      2'd0:    id_placed_c = {24'd0, data_byte_i};
      2'd1:    id_placed_c = {16'd0, data_byte_i, 8'd0};
      2'd2:    id_placed_c = {8'd0, data_byte_i, 16'd0};
      default: id_placed_c = {data_byte_i, 24'd0};
    endcase
  end

  assign ls_base_c        = (prefix_count_q == PREFIX_FIRST) ? 32'd0 : length_shift_q;
  assign bytes_left_dec_c = bytes_left_q - 32'd1;

  always_comb begin
    in_payload_d    = in_payload_q;
    prefix_count_d  = prefix_count_q;
    length_shift_d  = length_shift_q;
    bytes_left_d    = bytes_left_q;
    payload_index_d = payload_index_q;
    id_capture_d    = id_capture_q;
    next_offset_d   = next_offset_q;
    record_start_d  = record_start_q;
    next_seq_d      = next_seq_q;
    emit_c          = 1'b0;
    emit_len_c      = 32'd0;
    if (accept) begin
      next_offset_d = next_offset_q + OFFSET_BITS'(1);
      if (!in_payload_q) begin
        if (prefix_count_q == PREFIX_FIRST) begin
          record_start_d = next_offset_q;
        end
        length_shift_d = ls_base_c | byte_placed_c;
        if (prefix_count_q == PREFIX_LAST) begin
          prefix_count_d  = PREFIX_FIRST;
          id_capture_d    = 32'd0;
          payload_index_d = 4'd0;
          if (length_shift_d == 32'd0) begin
            emit_c = 1'b1;
          end else begin
            in_payload_d = 1'b1;
            bytes_left_d = length_shift_d;
          end
        end else begin
          prefix_count_d = prefix_count_q + 2'd1;
        end
      end else begin
        if (payload_index_q >= ID_FIRST_INDEX && payload_index_q < ID_END_INDEX) begin
          id_capture_d = id_capture_q | id_placed_c;
        end
        if (payload_index_q < ID_END_INDEX) begin
          payload_index_d = payload_index_q + 4'd1;
        end
        bytes_left_d = bytes_left_dec_c;
        if (bytes_left_dec_c == 32'd0) begin
          in_payload_d = 1'b0;
          emit_c       = 1'b1;
          emit_len_c   = length_shift_q;
        end
      end
      if (emit_c) begin
        next_seq_d = next_seq_q + 32'd1;
      end
    end
    if (cfg_wr && paddr[2] == REG_FIRST_SEQUENCE) begin
      next_seq_d = pwdata;
    end
    if (cfg_wr && paddr[2] == REG_FIRST_OFFSET) begin
      next_offset_d  = OFFSET_BITS'(pwdata);
      record_start_d = OFFSET_BITS'(pwdata);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_seq_q     <= FIRST_SEQUENCE_RST;
      first_off_q     <= FIRST_OFFSET_RST;
      in_payload_q    <= 1'b0;
      prefix_count_q  <= PREFIX_FIRST;
      length_shift_q  <= 32'd0;
      bytes_left_q    <= 32'd0;
      payload_index_q <= 4'd0;
      id_capture_q    <= 32'd0;
      next_offset_q   <= OFFSET_BITS'(FIRST_OFFSET_RST);
      record_start_q  <= OFFSET_BITS'(FIRST_OFFSET_RST);
      next_seq_q      <= FIRST_SEQUENCE_RST;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_FIRST_SEQUENCE) begin
        first_seq_q <= pwdata;
      end
      if (cfg_wr && paddr[2] == REG_FIRST_OFFSET) begin
        first_off_q <= pwdata;
      end
      in_payload_q    <= in_payload_d;
      prefix_count_q  <= prefix_count_d;
      length_shift_q  <= length_shift_d;
      bytes_left_q    <= bytes_left_d;
      payload_index_q <= payload_index_d;
      id_capture_q    <= id_capture_d;
      next_offset_q   <= next_offset_d;
      record_start_q  <= record_start_d;
      next_seq_q      <= next_seq_d;
      if (emit_c) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_c) begin
      record_offset_o   <= 32'(record_start_q);
      record_sequence_o <= next_seq_q;
      payload_length_o  <= emit_len_c;
      file_id_valid_o   <= (emit_len_c >= ID_MIN_LENGTH);
      file_id_o         <= (emit_len_c >= ID_MIN_LENGTH) ? id_capture_d : 32'd0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_seq_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_c && !cfg_wr |=> next_seq_q == $past(next_seq_q) + 32'd1)
    else $error("sequence number did not advance after a result");

  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !file_id_valid_o |-> file_id_o == 32'd0)
    else $error("file id not cleared for a short record");

  a_payload_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> bytes_left_q != 32'd0 && prefix_count_q == PREFIX_FIRST)
    else $error("payload phase with no bytes left or prefix in progress");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(record_sequence_o))
    else $error("result changed while stalled");

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lprd_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 180;

  typedef struct packed {
    logic [31:0] start_offset;
    logic [31:0] seq_num;
    logic [31:0] length;
    logic [31:0] fid;
    logic        fid_ok;
  } rec_t;

  typedef enum logic [1:0] {ROW_REC, ROW_HEAD, ROW_REST, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic        regsel;
    logic [31:0] value;
    logic [7:0]  fill;
    logic [7:0]  cut;
    logic        typed;
    rec_t        exp;
  } row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [7:0]        data_byte_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [31:0]       record_offset_o;
  logic [31:0]       record_sequence_o;
  logic [31:0]       payload_length_o;
  logic [31:0]       file_id_o;
  logic              file_id_valid_o;

  length_prefixed_record_deframer u_top (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_stall_o,
    .data_byte_i,
    .out_valid_o,
    .out_stall_i,
    .record_offset_o,
    .record_sequence_o,
    .payload_length_o,
    .file_id_o,
    .file_id_valid_o
  );

  always #5 clk_i = ~clk_i;

  // deframer state mirror
  logic [31:0] cfg_seq_value;
  logic [31:0] cfg_off_value;
  logic        st_payload;
  logic [1:0]  pfx_cnt;
  logic [31:0] len_acc;
  logic [31:0] remaining;
  logic [3:0]  pay_idx;
  logic [31:0] id_acc;
  logic [31:0] wr_offset;
  logic [31:0] start_off;
  logic [31:0] seq_next;

  rec_t        pending_records[$];
  logic [7:0]  frame_q[$];
  rec_t        typed_rec;
  rec_t        want;
  bit          use_typed = 1'b0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int          errors = 0;
  int          cycles = 0;
  int          bytes_sent = 0;
  int          records_checked = 0;
  int          reg_writes = 0;
  int          stall_run = 0;
  row_t        plan [18];

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] wanted);
    $display("MISMATCH %s: got %h want %h", what, got, wanted);
    errors++;
  endtask

  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return 32'd0;
    if (r < 45) return $urandom_range(1, 7);
    if (r < 86) return $urandom_range(8, 24);
    if (r < 99) return $urandom_range(25, 90);
    return $urandom_range(200, 400);
  endfunction

  function automatic void clear_model();
    cfg_seq_value = FIRST_SEQUENCE_RST;
    cfg_off_value = FIRST_OFFSET_RST;
    st_payload = 1'b0;
    pfx_cnt = PREFIX_FIRST;
    len_acc = '0;
    remaining = '0;
    pay_idx = '0;
    id_acc = '0;
    wr_offset = cfg_off_value;
    start_off = cfg_off_value;
    seq_next = cfg_seq_value;
  endfunction

  function automatic void load_register(input logic sel, input logic [31:0] value);
    if (sel == REG_FIRST_SEQUENCE) begin
      cfg_seq_value = value;
      seq_next = value;
    end else begin
      cfg_off_value = value;
      wr_offset = value;
      start_off = value;
    end
  endfunction

  function automatic rec_t close_record(input logic [31:0] len);
    rec_t r;
    r.start_offset = start_off;
    r.seq_num = seq_next;
    r.length = len;
    r.fid_ok = len >= ID_MIN_LENGTH;
    r.fid = r.fid_ok ? id_acc : 32'd0;
    seq_next = seq_next + 32'd1;
    return r;
  endfunction

  function automatic bit deframe_byte(input logic [7:0] b, output rec_t r);
    bit fire;
    fire = 1'b0;
    r = '0;
    if (!st_payload) begin
      if (pfx_cnt == PREFIX_FIRST) begin
        start_off = wr_offset;
        len_acc = '0;
      end
      len_acc = len_acc | (32'(b) << (8 * pfx_cnt));
      if (pfx_cnt == PREFIX_LAST) begin
        pfx_cnt = PREFIX_FIRST;
        id_acc = '0;
        pay_idx = '0;
        if (len_acc == 32'd0) begin
          r = close_record(32'd0);
          fire = 1'b1;
        end else begin
          st_payload = 1'b1;
          remaining = len_acc;
        end
      end else begin
        pfx_cnt = pfx_cnt + 2'd1;
      end
    end else begin
      if (pay_idx >= ID_FIRST_INDEX && pay_idx < ID_END_INDEX) begin
        id_acc = id_acc | (32'(b) << (8 * (pay_idx - ID_FIRST_INDEX)));
      end
      if (pay_idx < ID_END_INDEX) pay_idx = pay_idx + 4'd1;
      remaining = remaining - 32'd1;
      if (remaining == 32'd0) begin
        st_payload = 1'b0;
        r = close_record(len_acc);
        fire = 1'b1;
      end
    end
    wr_offset = wr_offset + 32'd1;
    return fire;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    rec_t got;
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    if (deframe_byte(b, got)) begin
      pending_records = {pending_records, (use_typed ? typed_rec : got)};
    end
  endtask

  task automatic load_frame(input logic [31:0] len, input logic [7:0] fill,
                            input bit random_payload);
    for (int i = 0; i < 4; i++) frame_q = {frame_q, len[8*i +: 8]};
    for (int i = 0; i < int'(len); i++) begin
      frame_q = {frame_q, (random_payload ? 8'($urandom) : 8'(fill + i))};
    end
  endtask

  task automatic flush_frame();
    while (frame_q.size() != 0) send_byte(frame_q.pop_front());
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic sel, input logic [31:0] value);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    load_register(sel, value);
    reg_writes++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) flag_mismatch("register readback", prdata, value);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      out_stall_i <= !out_calm && ($urandom_range(0, 2) == 0);
      stall_run = pick_gap(1'b0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_records.size() == 0) begin
        flag_mismatch("unexpected record, offset", record_offset_o, 32'd0);
      end else begin
        want = pending_records.pop_front();
        records_checked++;
        if (record_offset_o !== want.start_offset) begin
          flag_mismatch("record_offset", record_offset_o, want.start_offset);
        end
        if (record_sequence_o !== want.seq_num) begin
          flag_mismatch("record_sequence", record_sequence_o, want.seq_num);
        end
        if (payload_length_o !== want.length) begin
          flag_mismatch("payload_length", payload_length_o, want.length);
        end
        if (file_id_o !== want.fid) flag_mismatch("file_id", file_id_o, want.fid);
        if (file_id_valid_o !== want.fid_ok) begin
          flag_mismatch("file_id_valid", 32'(file_id_valid_o), 32'(want.fid_ok));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d records outstanding", cycles,
               pending_records.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic first_sel;
    logic [31:0] seq_pick;
    logic [31:0] off_pick;

    plan = '{
      '{ROW_REC, REG_FIRST_SEQUENCE, 32'd0, 8'h00, 8'd0, 1'b1,
        '{32'h0000_0000, 32'd1, 32'd0, 32'h0000_0000, 1'b0}},
      '{ROW_REC, REG_FIRST_SEQUENCE, 32'd8, 8'hF8, 8'd0, 1'b1,
        '{32'h0000_0004, 32'd2, 32'd8, 32'hFFFE_FDFC, 1'b1}},
      '{ROW_REC, REG_FIRST_SEQUENCE, 32'd7, 8'h01, 8'd0, 1'b1,
        '{32'h0000_0010, 32'd3, 32'd7, 32'h0000_0000, 1'b0}},
      '{ROW_REC, REG_FIRST_SEQUENCE, 32'd1, 8'h80, 8'd0, 1'b0, '0},
      '{ROW_CFG, REG_FIRST_SEQUENCE, 32'hFFFF_FFFF, 8'h00, 8'd0, 1'b0, '0},
      '{ROW_CFG, REG_FIRST_OFFSET, 32'hFFFF_FFFC, 8'h00, 8'd0, 1'b0, '0},
      '{ROW_REC, REG_FIRST_SEQUENCE, 32'd0, 8'h00, 8'd0, 1'b1,
        '{32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'd0, 32'h0000_0000, 1'b0}},
      '{ROW_REC, REG_FIRST_SEQUENCE, 32'd9, 8'h00, 8'd0, 1'b1,
        '{32'h0000_0000, 32'd0, 32'd9, 32'h0706_0504, 1'b1}},
      '{ROW_REC, REG_FIRST_SEQUENCE, 32'd300, 8'h33, 8'd0, 1'b0, '0},
      '{ROW_HEAD, REG_FIRST_SEQUENCE, 32'd12, 8'h40, 8'd2, 1'b0, '0},
      '{ROW_CFG, REG_FIRST_OFFSET, 32'h0000_1000, 8'h00, 8'd0, 1'b0, '0},
      '{ROW_REST, REG_FIRST_SEQUENCE, 32'd0, 8'h00, 8'd0, 1'b0, '0},
      '{ROW_HEAD, REG_FIRST_SEQUENCE, 32'd20, 8'h50, 8'd9, 1'b0, '0},
      '{ROW_CFG, REG_FIRST_SEQUENCE, 32'd100, 8'h00, 8'd0, 1'b0, '0},
      '{ROW_CFG, REG_FIRST_OFFSET, 32'h0000_2000, 8'h00, 8'd0, 1'b0, '0},
      '{ROW_REST, REG_FIRST_SEQUENCE, 32'd0, 8'h00, 8'd0, 1'b0, '0},
      '{ROW_REC, REG_FIRST_SEQUENCE, 32'd0, 8'h00, 8'd0, 1'b1,
        '{32'h0000_200F, 32'd101, 32'd0, 32'h0000_0000, 1'b0}},
      '{ROW_REC, REG_FIRST_SEQUENCE, 32'd24, 8'hA5, 8'd0, 1'b0, '0}
    };

    clear_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      use_typed = plan[i].typed;
      typed_rec = plan[i].exp;
      case (plan[i].kind)
        ROW_CFG: begin
          set_reg(plan[i].regsel, plan[i].value);
        end
        ROW_REC: begin
          load_frame(plan[i].value, plan[i].fill, 1'b0);
          flush_frame();
        end
        ROW_HEAD: begin
          load_frame(plan[i].value, plan[i].fill, 1'b0);
          repeat (plan[i].cut) send_byte(frame_q.pop_front());
        end
        default: begin
          flush_frame();
        end
      endcase
    end
    use_typed = 1'b0;

    // phases end at arbitrary bytes, so writes often land mid-record
    for (int phase = 0; phase < PHASES; phase++) begin
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      case (phase)
        1: begin
          seq_pick = 32'hFFFF_FFF8;
          off_pick = 32'hFFFF_FF80;
        end
        2: begin
          seq_pick = 32'd0;
          off_pick = 32'd0;
        end
        3: begin
          seq_pick = 32'hFFFF_FFFF;
          off_pick = 32'hFFFF_FFFF;
        end
        default: begin
          seq_pick = $urandom;
          off_pick = $urandom;
        end
      endcase
      first_sel = $urandom_range(0, 1) ? REG_FIRST_SEQUENCE : REG_FIRST_OFFSET;
      set_reg(first_sel, first_sel == REG_FIRST_SEQUENCE ? seq_pick : off_pick);
      if ($urandom_range(0, 4) != 0) begin
        set_reg(!first_sel, first_sel == REG_FIRST_SEQUENCE ? off_pick : seq_pick);
      end
      for (int n = 0; n < PHASE_BYTES; n++) begin
        if (frame_q.size() == 0) load_frame(pick_length(), 8'h00, 1'b1);
        send_byte(frame_q.pop_front());
      end
    end
    flush_frame();

    // open a record whose length can never complete
    repeat (4) send_byte(8'hFF);
    repeat (3) send_byte(8'($urandom));
    settle();

    $display("Checked %0d records from %0d stream bytes across %0d register writes",
             records_checked, bytes_sent, reg_writes);
    $display("Stream had empty, short and ID-carrying records, counter wraps, "
             , "writes mid-record and random stalls on both sides");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
